FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the box filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bf5_pkg.sv
// Types and constants of the 5x5 box filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bf5_pkg;

	localparam int PIX_W       = 8;
	localparam int SLOTS       = 5;
	localparam int SLOT_W      = 3;
	localparam int WIN         = 5;
	localparam int VSUM_W      = 11;
	localparam int SUM_W       = 13;
	localparam int ROUND_BIAS  = 12;
	localparam int RECIP       = 5243;
	localparam int DIV_SHIFT   = 17;
	localparam int PROD_W      = 26;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int MIN_DIM     = 5;
	localparam int W_REG_W     = 10;
	localparam int H_REG_W     = 12;
	localparam int ROW_W       = 13;
	localparam int ADDR_W      = 3;
	localparam int APB_DATA_W  = 32;
	localparam int WIDTH_RST   = 440;
	localparam int HEIGHT_RST  = 330;
	localparam logic [1:0] LAST_STEP = 2'd2;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} bf5_op_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} bf5_reg_t;

	// one column of the vertical window, summed
	typedef struct packed {
		logic [VSUM_W-1:0] vsum;
		logic              first_col;
		logic              last_col;
		logic              emit;
		logic              eof_row;
	} bf5_col_t;

	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic             eof;
		logic             last;
	} bf5_res_t;

endpackage

FILE: rtl/core/bf5_fifo.sv
// Small register FIFO used between front and back and at the result side.
// Depends on bf5_pkg (imported for uniformity) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bf5_fifo import bf5_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [DATA_W-1:0]          wdata,
	input  logic                       pop,
	output logic [DATA_W-1:0]          rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = store_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push && (count_q == CNT_W'(DEPTH)), do_pop, "fifo overflow")

endmodule

FILE: rtl/core/bf5_front.sv
// Front end: takes pixel/drain transactions, keeps the position counters and
// five line memories, and emits summed window columns. Depends on bf5_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bf5_front import bf5_pkg::*; #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_restart,
	input  logic [$clog2(MAX_WIDTH)-1:0] last_col,
	input  logic [H_REG_W-1:0]           frame_rows,
	input  logic                         push,
	output logic                         full,
	input  logic                         opcode,
	input  logic [PIX_W-1:0]             pixel,
	input  logic [QCNT_W-1:0]            q_count,
	output logic                         col_push,
	output bf5_col_t                     col_data
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int QOCC_W = QCNT_W + 1;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic              drain_q;

	logic              accept;
	logic              is_pix;
	logic              item_ok;
	logic              col_end;
	logic              row_hi;
	logic              row_ok;
	logic [ROW_W-1:0]  rows_ext;
	logic [QOCC_W-1:0] occ;
	logic              frame_done;
	logic              pos_zero;

	logic [SLOT_W-1:0] sel [WIN];
	logic [SLOT_W-1:0] rows_back;
	logic [SLOT_W:0]   slot_sum;

	logic              v_s1;
	logic [SLOT_W-1:0] sel_s1 [WIN];
	logic              byp_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              first_s1;
	logic              last_s1;
	logic              emit_s1;
	logic              eof_s1;
	logic [PIX_W-1:0]  rd_pix [SLOTS];
	logic [PIX_W-1:0]  tap_pix [WIN];
	logic [VSUM_W-1:0] vsum;

	assign occ      = {1'b0, q_count} + QOCC_W'(v_s1);
	assign full     = (occ >= QOCC_W'(QUEUE_DEPTH));
	assign accept   = push && !full;
	assign is_pix   = (opcode == OP_PIXEL);
	assign item_ok  = accept && (is_pix ? !drain_q : drain_q);
	assign col_end  = (col_q == last_col);
	assign rows_ext = ROW_W'(frame_rows);
	assign row_hi   = (row_q == rows_ext + ROW_W'(1));
	assign row_ok   = (row_q >= ROW_W'(2));

	assign frame_done = item_ok && col_end && drain_q && row_hi;
	assign pos_zero   = (row_q == '0) && !drain_q && (slot_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			drain_q <= 1'b0;
		end else if (cfg_restart) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			drain_q <= 1'b0;
		end else if (item_ok) begin
			if (col_end) begin
				col_q <= '0;
				if (drain_q && row_hi) begin
					row_q   <= '0;
					slot_q  <= '0;
					drain_q <= 1'b0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					slot_q <= (slot_q == SLOT_W'(SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (!drain_q && (row_q + ROW_W'(1) == rows_ext)) begin
						drain_q <= 1'b1;
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Tap k holds row (row-4+k) clamped into the frame; rows_back is how many
	// rows back that lands, turned into a line memory slot.
	always_comb begin
		rows_back = '0;
		slot_sum  = '0;
		for (int k = 0; k < WIN; k++) begin
			if (drain_q) begin
				if (k == WIN - 1 || (row_hi && k == WIN - 2)) begin
					rows_back = row_hi ? SLOT_W'(2) : SLOT_W'(1);
				end else begin
					rows_back = SLOT_W'(WIN - 1 - k);
				end
			end else if (row_q == ROW_W'(2) && k <= 1) begin
				rows_back = SLOT_W'(2);
			end else if (row_q == ROW_W'(3) && k == 0) begin
				rows_back = SLOT_W'(3);
			end else begin
				rows_back = SLOT_W'(WIN - 1 - k);
			end
			slot_sum = {1'b0, slot_q} + (SLOT_W+1)'(SLOTS) - {1'b0, rows_back};
			if (slot_sum >= (SLOT_W+1)'(SLOTS)) begin
				slot_sum = slot_sum - (SLOT_W+1)'(SLOTS);
			end
			sel[k] = slot_sum[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= item_ok && row_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ok) begin
			sel_s1   <= sel;
			byp_s1   <= !drain_q;
			pix_s1   <= pixel;
			first_s1 <= (col_q == '0);
			last_s1  <= col_end;
			emit_s1  <= (col_q >= COL_W'(2));
			eof_s1   <= drain_q && row_hi;
		end
	end

	for (genvar m = 0; m < SLOTS; m++) begin : g_slot
		logic [PIX_W-1:0] line_mem [MAX_WIDTH];
		logic [PIX_W-1:0] rd_s1;

		always_ff @(posedge clk) begin
			if (item_ok && is_pix && (slot_q == SLOT_W'(m))) begin
				line_mem[col_q] <= pixel;
			end
			if (item_ok) begin
				rd_s1 <= line_mem[col_q];
			end
		end

		assign rd_pix[m] = rd_s1;
	end

	// The current row's pixel is not in memory yet at read time: bypass it.
	always_comb begin
		vsum = '0;
		for (int k = 0; k < WIN; k++) begin
			if (k == WIN - 1 && byp_s1) begin
				tap_pix[k] = pix_s1;
			end else begin
				tap_pix[k] = rd_pix[sel_s1[k]];
			end
			vsum = vsum + VSUM_W'(tap_pix[k]);
		end
	end

	assign col_push           = v_s1;
	assign col_data.vsum      = vsum;
	assign col_data.first_col = first_s1;
	assign col_data.last_col  = last_s1;
	assign col_data.emit      = emit_s1;
	assign col_data.eof_row   = eof_s1;

	`ASSERT_IMPLIES(a_slot_range, clk, arst_n, 1'b1, slot_q < SLOT_W'(SLOTS), "slot out of range")
	`ASSERT_NEXT(a_frame_wrap, clk, arst_n, frame_done && !cfg_restart, pos_zero, "no frame wrap")

endmodule

FILE: rtl/core/bf5_back.sv
// Back end: horizontal 5-column window over the column sums, rounding
// divide by 25 and result formation. Depends on bf5_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bf5_back import bf5_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              col_empty,
	input  bf5_col_t          col_head,
	output logic              col_pop,
	input  logic [QCNT_W-1:0] res_count,
	output logic              res_push,
	output bf5_res_t          res_data
);

	localparam int ROCC_W = QCNT_W + 1;

	logic [VSUM_W-1:0] win_q   [WIN];
	logic [VSUM_W-1:0] win_nxt [WIN];
	logic [SUM_W-1:0]  sum_nxt;
	logic [1:0]        step_q;
	logic [ROCC_W-1:0] occ;
	logic              issue;
	logic              last_step;

	logic              v_b1;
	logic [SUM_W-1:0]  sum_b1;
	logic              eof_b1;
	logic              last_b1;
	logic [PROD_W-1:0] prod;

	logic              v_b2;
	logic [PIX_W-1:0]  mean_b2;
	logic              eof_b2;
	logic              last_b2;

	// reserve result room for everything in flight so the pipe never stalls
	assign occ       = {1'b0, res_count} + ROCC_W'(v_b1) + ROCC_W'(v_b2);
	assign issue     = !col_empty && (occ < ROCC_W'(QUEUE_DEPTH));
	assign last_step = col_head.last_col ? (step_q == LAST_STEP) : 1'b1;
	assign col_pop   = issue && last_step;

	// Row start fills the window with column 0; the row end shifts the last
	// column in three times to replicate the right border.
	always_comb begin
		sum_nxt = '0;
		for (int k = 0; k < WIN; k++) begin
			if (col_head.first_col || k == WIN - 1) begin
				win_nxt[k] = col_head.vsum;
			end else begin
				win_nxt[k] = win_q[k+1];
			end
			sum_nxt = sum_nxt + SUM_W'(win_nxt[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				win_q[k] <= '0;
			end
			step_q <= '0;
			v_b1   <= 1'b0;
			v_b2   <= 1'b0;
		end else begin
			if (issue) begin
				win_q <= win_nxt;
				if (col_head.last_col && !last_step) begin
					step_q <= step_q + 2'd1;
				end else begin
					step_q <= '0;
				end
			end
			v_b1 <= issue && col_head.emit;
			v_b2 <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_b1  <= sum_nxt;
			eof_b1  <= col_head.eof_row && col_head.last_col && last_step;
			last_b1 <= last_step;
		end
	end

	// (sum + 12) / 25 as a multiply by the scaled reciprocal
	assign prod = PROD_W'(sum_b1 + SUM_W'(ROUND_BIAS)) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		mean_b2 <= prod[DIV_SHIFT +: PIX_W];
		eof_b2  <= eof_b1;
		last_b2 <= last_b1;
	end

	assign res_push      = v_b2;
	assign res_data.mean = mean_b2;
	assign res_data.eof  = eof_b2;
	assign res_data.last = last_b2;

	`ASSERT_IMPLIES(a_step_on_row_end, clk, arst_n, step_q != 2'd0, !col_empty && col_head.last_col, "border step without a row-end column")

endmodule

FILE: rtl/core/box_filter_5x5_replicate_border.sv
// 5x5 box mean filter with replicated borders: top level.
// Holds the configuration registers and joins front, back and the queues.
// Depends on bf5_pkg, bf5_fifo, bf5_front, bf5_back.
//
// Usage:
//   Input queue: push/full, with opcode and pixel. Pixels of one frame come
//   in raster order (opcode 0), then 2*width drain transactions (opcode 1)
//   stand for the two replicated rows below the frame. Items of the wrong
//   kind for the current phase are taken and dropped.
//   Result queue: empty/pop, with mean_value, end_of_frame and last_of_run.
//   Results come in raster order; one input releases up to three results.
//   Config: APB, frame_width at 0x0 and frame_height at 0x4. A write restarts
//   the frame; write only while the block is idle.
// Flow:
//   One transaction per clock is accepted while full is low. The result side
//   moves one result per clock while it has columns and room, so a row of w
//   inputs yields w results and input stalls at each row end. A result passes
//   the column queue, window and divide registers, result queue; border
//   results follow. When pop stays low the queues fill and full rises.
// Reset:
//   Clears position, queues and window; registers return to 440 x 330. Line
//   memories are not cleared: every pixel read was written earlier in the
//   same frame.
`timescale 1ns / 1ps

module box_filter_5x5_replicate_border import bf5_pkg::*; #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_W-1:0]      mean_value,
	output logic                  end_of_frame,
	output logic                  last_of_run,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW    = (COL_W + 1 > W_REG_W) ? COL_W + 1 : W_REG_W;

	logic [W_REG_W-1:0] frame_width_q;
	logic [H_REG_W-1:0] frame_height_q;
	logic               cfg_wr;
	bf5_reg_t           reg_idx;
	logic [EW-1:0]      width_ext;
	logic [EW-1:0]      eff_width;
	logic [COL_W-1:0]   last_col;
	logic [H_REG_W-1:0] frame_rows;

	logic               col_push;
	bf5_col_t           col_wdata;
	bf5_col_t           col_head;
	logic               col_pop;
	logic               col_empty;
	logic [QCNT_W-1:0]  col_count;

	logic               res_push;
	bf5_res_t           res_wdata;
	bf5_res_t           res_head;
	logic [QCNT_W-1:0]  res_count;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = bf5_reg_t'(paddr[ADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= W_REG_W'(WIDTH_RST);
			frame_height_q <= H_REG_W'(HEIGHT_RST);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FRAME_WIDTH: begin
					frame_width_q <= pwdata[W_REG_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[H_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// effective size: width saturates to [5, MAX_WIDTH], height to at least 5
	assign width_ext = EW'(frame_width_q);
	always_comb begin
		if (width_ext < EW'(MIN_DIM)) begin
			eff_width = EW'(MIN_DIM);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = width_ext;
		end
	end
	assign last_col   = COL_W'(eff_width - EW'(1));
	assign frame_rows = (frame_height_q < H_REG_W'(MIN_DIM)) ? H_REG_W'(MIN_DIM)
	                                                         : frame_height_q;

	bf5_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_restart (cfg_wr),
		.last_col    (last_col),
		.frame_rows  (frame_rows),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.pixel       (pixel),
		.q_count     (col_count),
		.col_push    (col_push),
		.col_data    (col_wdata)
	);

	bf5_fifo #(
		.DATA_W ($bits(bf5_col_t)),
		.DEPTH  (QUEUE_DEPTH)
	) u_col_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (col_push),
		.wdata  (col_wdata),
		.pop    (col_pop),
		.rdata  (col_head),
		.empty  (col_empty),
		.count  (col_count)
	);

	bf5_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_empty (col_empty),
		.col_head  (col_head),
		.col_pop   (col_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_wdata)
	);

	bf5_fifo #(
		.DATA_W ($bits(bf5_res_t)),
		.DEPTH  (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (pop && !empty),
		.rdata  (res_head),
		.empty  (empty),
		.count  (res_count)
	);

	assign mean_value   = res_head.mean;
	assign end_of_frame = res_head.eof;
	assign last_of_run  = res_head.last;

endmodule
